// ===== rtl/core/mm_pkg.sv =====
`timescale 1ns / 1ps

package mm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int DIM_RESET_VAL = 8;
  localparam int DIM_W         = 4;
  localparam int IDX_W         = 3;
  localparam int REQ_W         = 2;
  localparam int VAL_W         = 32;
  localparam int ACC_W         = 64;
  localparam int FRAC_W        = 16;
  localparam int CFG_IDX_W     = 2;

  // Command queue between front and back; depth is a power of two so the
  // pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [ACC_W-1:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_LEFT  = 2'd0,
    REQ_LOAD_RIGHT = 2'd1,
    REQ_READ       = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_ROWS  = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_RIGHT_COLS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_WAIT,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    req_t             op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [DIM_W-1:0] terms;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] left_rows;
    logic [DIM_W-1:0] inner_size;
    logic [DIM_W-1:0] right_cols;
  } dims_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  typedef struct packed {
    logic idle;
    logic done;
  } bk_stat_t;

  // Zero acts as one, anything above the store size acts as the store size.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > max_dim) begin
      r = DIM_W'(max_dim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mm_front.sv =====
`timescale 1ns / 1ps

module mm_front #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]       cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mm_pkg::REQ_W-1:0]       in_req_type,
  input  logic [mm_pkg::IDX_W-1:0]       in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]       in_col_index,
  input  logic signed [mm_pkg::VAL_W-1:0] in_elem_value,
  input  logic                           q_full,
  output logic                           cmd_push,
  output mm_pkg::cmd_t                   cmd,
  output mm_pkg::dims_t                  dims
);
  import mm_pkg::*;

  localparam logic [DIM_W-1:0] DIM_RST =
    DIM_W'((DIM_RESET_VAL > MAX_DIM) ? MAX_DIM : DIM_RESET_VAL);

  dims_t dims_r, dims_nxt;
  logic  keep;

  assign cfg_ready = 1'b1;

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT_ROWS:  dims_nxt.left_rows  = clamp_dim(cfg_data, MAX_DIM);
        CFG_INNER_SIZE: dims_nxt.inner_size = clamp_dim(cfg_data, MAX_DIM);
        CFG_RIGHT_COLS: dims_nxt.right_cols = clamp_dim(cfg_data, MAX_DIM);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= '{left_rows: DIM_RST, inner_size: DIM_RST, right_cols: DIM_RST};
    end else begin
      dims_r <= dims_nxt;
    end
  end

  // Drop loads outside the store, reads outside the product, unused codes.
  always_comb begin
    case (in_req_type)
      REQ_LOAD_LEFT, REQ_LOAD_RIGHT: begin
        keep = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
      end
      REQ_READ: begin
        keep = ({1'b0, in_row_index} < dims_r.left_rows) &&
               ({1'b0, in_col_index} < dims_r.right_cols);
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall  = q_full;
  assign cmd_push  = in_valid && !q_full && keep;
  assign cmd.op    = req_t'(in_req_type);
  assign cmd.row   = in_row_index;
  assign cmd.col   = in_col_index;
  assign cmd.value = in_elem_value;
  assign cmd.terms = dims_r.inner_size;
  assign dims      = dims_r;

endmodule

// ===== rtl/core/mm_queue.sv =====
`timescale 1ns / 1ps

module mm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mm_pkg::cmd_t    cmd_in,
  input  logic            pop,
  output mm_pkg::cmd_t    cmd_out,
  output mm_pkg::q_stat_t stat
);
  import mm_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (!push && pop) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_out    = entries[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// ===== rtl/core/mm_back.sv =====
`timescale 1ns / 1ps

module mm_back #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mm_pkg::cmd_t                    cmd,
  input  logic                            q_empty,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [mm_pkg::VAL_W-1:0] out_product_value,
  output logic [mm_pkg::IDX_W-1:0]        out_row,
  output logic [mm_pkg::IDX_W-1:0]        out_col,
  output logic                            out_saturated,
  output mm_pkg::bk_stat_t                stat
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [VAL_W-1:0] left_mem  [DEPTH];
  logic [VAL_W-1:0] right_mem [DEPTH];

  bk_state_t               state_r, state_nxt;
  logic [IDX_W-1:0]        row_r, col_r;
  logic [DIM_W-1:0]        terms_r, k_r;
  logic signed [VAL_W-1:0] a_rd_r, b_rd_r;
  logic                    rd_v_r, rd_last_r;
  logic signed [ACC_W-1:0] prod_r, acc_r;
  logic                    prod_v_r, prod_last_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic                    out_sat_r;
  logic                    start, issue, last_issue, out_free, out_load;
  logic                    we_left, we_right, sat_hi, sat_lo;
  logic [ADDR_W-1:0]       wr_addr, rd_addr_l, rd_addr_r;

  assign last_issue = (DIM_W'(k_r + 1'b1) == terms_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (cmd.op == REQ_READ) begin
            start     = 1'b1;
            state_nxt = BK_ISSUE;
          end
        end
      end
      BK_ISSUE: begin
        issue = 1'b1;
        if (last_issue) begin
          state_nxt = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (prod_v_r && prod_last_r) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign we_left   = pop && (cmd.op == REQ_LOAD_LEFT);
  assign we_right  = pop && (cmd.op == REQ_LOAD_RIGHT);
  assign wr_addr   = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
  assign rd_addr_l = ADDR_W'(int'(row_r) * MAX_DIM + int'(k_r));
  assign rd_addr_r = ADDR_W'(int'(k_r) * MAX_DIM + int'(col_r));

  always_ff @(posedge clk) begin
    if (we_left) begin
      left_mem[wr_addr] <= cmd.value;
    end
    if (we_right) begin
      right_mem[wr_addr] <= cmd.value;
    end
    a_rd_r <= left_mem[rd_addr_l];
    b_rd_r <= right_mem[rd_addr_r];
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= issue;
      prod_v_r    <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Term = floor(a*b / 2^16), summed in a wide accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      row_r   <= cmd.row;
      col_r   <= cmd.col;
      terms_r <= cmd.terms;
      k_r     <= '0;
    end else if (issue) begin
      k_r <= DIM_W'(k_r + 1'b1);
    end
    rd_last_r   <= last_issue;
    prod_r      <= a_rd_r * b_rd_r;
    prod_last_r <= rd_last_r;
    if (start) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + (prod_r >>> FRAC_W);
    end
  end

  assign sat_hi = (acc_r > Q_MAX);
  assign sat_lo = (acc_r < Q_MIN);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= sat_hi ? Q_MAX[VAL_W-1:0] :
                     sat_lo ? Q_MIN[VAL_W-1:0] : acc_r[VAL_W-1:0];
      out_sat_r   <= sat_hi || sat_lo;
      out_row_r   <= row_r;
      out_col_r   <= col_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_saturated     = out_sat_r;
  assign stat.idle         = (state_r == BK_IDLE);
  assign stat.done         = (state_r == BK_DONE);

endmodule

// ===== rtl/core/matrix_multiply_top.sv =====
`timescale 1ns / 1ps

// Matrix multiply engine, signed Q16.16 elements.
// Input channel (in_valid / in_stall): each transfer loads one element of the
// left (req 0) or right (req 1) matrix, or asks for one product element
// (req 2). Loads outside the store, reads outside the configured product and
// request code 3 are taken and dropped.
// Output channel (out_valid / out_stall): one transfer per kept read, in
// request order, with the saturated dot product and a saturation flag.
// Config channel (cfg_valid / cfg_ready, always ready): writes left_rows,
// inner_size, right_cols; 0 acts as 1, values above MAX_DIM clamp. Write
// only while the engine is idle.
// Timing: the back end takes one load per cycle while idle; a read holds the
// back end until its result is in the output register, one multiply-accumulate
// per cycle over the inner dimension through a single MAC; operand reads, products,
// the accumulator and the saturated result are registered in turn.
// A two-entry command queue lets the input side keep taking items while a
// read walks the inner dimension or a result waits in the output register.
// Reset clears the dimension registers to 8 (or MAX_DIM), empties the queue
// and the output register; element stores are not cleared.
// A stalled receiver holds the result in place; the back end then waits,
// the queue fills, and in_stall rises.

module matrix_multiply_top #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mm_pkg::REQ_W-1:0]        in_req_type,
  input  logic [mm_pkg::IDX_W-1:0]        in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [mm_pkg::VAL_W-1:0] in_elem_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [mm_pkg::VAL_W-1:0] out_product_value,
  output logic [mm_pkg::IDX_W-1:0]        out_row,
  output logic [mm_pkg::IDX_W-1:0]        out_col,
  output logic                            out_saturated
);
  import mm_pkg::*;

  cmd_t     push_cmd, head_cmd;
  logic     cmd_push, q_pop;
  q_stat_t  q_stat;
  dims_t    dims;
  bk_stat_t bk_stat;

  // Front: config registers, classify and drop, push kept commands.
  mm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_elem_value (in_elem_value),
    .q_full        (q_stat.full),
    .cmd_push      (cmd_push),
    .cmd           (push_cmd),
    .dims          (dims)
  );

  // Decouple the two sides.
  mm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .cmd_in  (push_cmd),
    .pop     (q_pop),
    .cmd_out (head_cmd),
    .stat    (q_stat)
  );

  // Back: element stores, MAC sequencer, saturation and output register.
  mm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (head_cmd),
    .q_empty           (q_stat.empty),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_saturated     (out_saturated),
    .stat              (bk_stat)
  );

  // Queue occupancy never passes its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  // Commands leave the queue only when present and the back end is idle.
  a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_stat.empty && bk_stat.idle))
    else $error("queue popped while empty or back end busy");

  // Dimension registers stay within 1..MAX_DIM.
  a_dims_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (dims.left_rows != '0) && (dims.inner_size != '0) && (dims.right_cols != '0) &&
    (int'(dims.left_rows) <= MAX_DIM) && (int'(dims.inner_size) <= MAX_DIM) &&
    (int'(dims.right_cols) <= MAX_DIM))
    else $error("dimension register out of range");

  // A new result comes only from a finished dot product.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.done))
    else $error("result raised without a finished read");

endmodule

// ===== tb/sv/matrix_multiply_top_test.sv =====
`timescale 1ns / 1ps

module matrix_multiply_top_test;
  import mm_pkg::*;

  localparam int DIM = MAX_DIM_DEF;
  // Request code and register index that the block must take and drop.
  localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  // Allow for two of the longest reads plus queue slack.
  localparam int SETTLE_CYCLES = 2 * (DIM + 4) + 8;
  localparam int LONG_HOLD     = 300;
  // Give the slowest legal run several times the time that it needs.
  localparam longint RUN_LIMIT_NS = 6_000_000;

  localparam logic signed [VAL_W-1:0] VAL_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN     = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] Q_ONE       = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] Q_MINUS_ONE = 32'shFFFF_0000;
  localparam logic signed [VAL_W-1:0] NEG_LSB     = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [REQ_W-1:0]        kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    sat;
  } product_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DIM_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type;
  logic [IDX_W-1:0]         in_row_index;
  logic [IDX_W-1:0]         in_col_index;
  logic signed [VAL_W-1:0]  in_elem_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VAL_W-1:0]  out_product_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_saturated;

  matrix_multiply_top #(
    .MAX_DIM(DIM)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_elem_value    (in_elem_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_product_value(out_product_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_saturated    (out_saturated)
  );

  // Mirror of the element stores and dimension registers, updated on every
  // accepted transfer. The written flags keep the stimulus away from reads
  // of elements that were never loaded.
  logic signed [VAL_W-1:0] left_mem  [DIM*DIM];
  logic signed [VAL_W-1:0] right_mem [DIM*DIM];
  bit                      left_set  [DIM*DIM];
  bit                      right_set [DIM*DIM];
  logic [DIM_W-1:0]        rows_eff;
  logic [DIM_W-1:0]        inner_eff;
  logic [DIM_W-1:0]        cols_eff;

  // Products still owed by the block, oldest first.
  product_t pending_products[$];
  int       errors;

  // Knobs for the idle and stall generators.
  bit gaps_on;
  bit stalls_on;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL matrix_multiply_top");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Zero counts as one; anything past the store size is capped.
  function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return DIM_W'(1);
    if (raw > DIM) return DIM_W'(DIM);
    return raw;
  endfunction

  // Sum the floored Q16.16 terms in 64 bits, then saturate to 32 bits.
  function automatic product_t dot_product(input logic [IDX_W-1:0] row,
                                           input logic [IDX_W-1:0] col);
    product_t p;
    longint   sum;
    longint   term;
    sum = 0;
    for (int k = 0; k < inner_eff; k++) begin
      term = longint'(left_mem[row*DIM+k]) * longint'(right_mem[k*DIM+col]);
      sum += term >>> FRAC_W;
    end
    p.row = row;
    p.col = col;
    p.sat = 1'b0;
    if (sum > Q_MAX) begin
      p.value = VAL_MAX;
      p.sat   = 1'b1;
    end else if (sum < Q_MIN) begin
      p.value = VAL_MIN;
      p.sat   = 1'b1;
    end else begin
      p.value = sum[VAL_W-1:0];
    end
    return p;
  endfunction

  // Apply one accepted transfer: loads update the stores, kept reads owe a
  // product, everything else is dropped.
  function automatic void accept_request(input request_t q);
    case (q.kind)
      REQ_LOAD_LEFT: begin
        left_mem[q.row*DIM+q.col] = q.value;
        left_set[q.row*DIM+q.col] = 1'b1;
      end
      REQ_LOAD_RIGHT: begin
        right_mem[q.row*DIM+q.col] = q.value;
        right_set[q.row*DIM+q.col] = 1'b1;
      end
      REQ_READ: begin
        if (q.row < rows_eff && q.col < cols_eff)
          pending_products.push_back(dot_product(q.row, q.col));
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: compare each output transfer with the oldest product.
  // ---------------------------------------------------------------------

  function automatic void report_mismatch(input string field,
                                          input logic [VAL_W-1:0] want,
                                          input logic [VAL_W-1:0] got);
    $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
    errors++;
  endfunction

  always @(posedge clk) begin : check_products
    product_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_products.size() == 0) begin
        $display("%0t unexpected result: expected none, actual row %0d col %0d value %h",
                 $time, out_row, out_col, out_product_value);
        errors++;
      end else begin
        want = pending_products.pop_front();
        if (out_product_value !== want.value)
          report_mismatch("product_value", want.value, out_product_value);
        if (out_row !== want.row)
          report_mismatch("out_row", VAL_W'(want.row), VAL_W'(out_row));
        if (out_col !== want.col)
          report_mismatch("out_col", VAL_W'(want.col), VAL_W'(out_col));
        if (out_saturated !== want.sat)
          report_mismatch("saturated", VAL_W'(want.sat), VAL_W'(out_saturated));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, mostly short, a few long; a requested hold
  // keeps out_stall high through the LONG_HOLD wait so the block backs up.
  // ---------------------------------------------------------------------

  initial begin : result_stall
    int stall_left;
    int r;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        stall_left   = 0;
        out_stall    = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if (stalls_on) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          stall_left = $urandom_range(6, 40);
          out_stall  = 1'b1;
        end else if (r < 25) begin
          stall_left = $urandom_range(0, 2);
          out_stall  = 1'b1;
        end else begin
          out_stall = 1'b0;
        end
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Idle cycles before the next transfer: mostly none, some short, few long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the
  // transfer with in_valid still high, so back-to-back items never drop it.
  task automatic send_request(input request_t q, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type   = q.kind;
    in_row_index  = q.row;
    in_col_index  = q.col;
    in_elem_value = q.value;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accept_request(q);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [VAL_W-1:0] value);
    request_t q;
    q = '{kind: kind, row: row, col: col, value: value};
    send_request(q, pick_gap());
  endtask

  // Hold the input idle until every owed product has come out, then let
  // any loads still in the queue drain before a register write.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_products.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dim(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
    cfg_index = index;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_LEFT_ROWS:  rows_eff  = effective_dim(data);
      CFG_INNER_SIZE: inner_eff = effective_dim(data);
      CFG_RIGHT_COLS: cols_eff  = effective_dim(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                          input logic [DIM_W-1:0] cols);
    drain_results();
    write_dim(CFG_LEFT_ROWS, rows);
    write_dim(CFG_INNER_SIZE, inner);
    write_dim(CFG_RIGHT_COLS, cols);
  endtask

  // Element values: small values within +/-4, full-range noise and the corners.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    int               r;
    v = $urandom;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = {{13{v[18]}}, v[18:0]};
    end else if (r >= 75) begin
      case ($urandom_range(0, 6))
        0: v = VAL_MAX;
        1: v = VAL_MIN;
        2: v = '0;
        3: v = Q_ONE;
        4: v = Q_MINUS_ONE;
        5: v = NEG_LSB;
        default: v = 32'd1;
      endcase
    end
    return $signed(v);
  endfunction

  // True when a read touches only loaded elements (or is dropped anyway).
  function automatic bit operands_ready(input logic [IDX_W-1:0] row,
                                        input logic [IDX_W-1:0] col);
    if (row >= rows_eff || col >= cols_eff) return 1'b1;
    for (int k = 0; k < inner_eff; k++)
      if (!left_set[row*DIM+k] || !right_set[k*DIM+col]) return 1'b0;
    return 1'b1;
  endfunction

  // Turn a read whose operands are not all loaded into a load of the first
  // missing one; repeated tries fill the row and column in.
  function automatic request_t missing_operand(input request_t q);
    for (int k = 0; k < inner_eff; k++) begin
      if (!left_set[q.row*DIM+k]) begin
        q.kind = REQ_LOAD_LEFT;
        q.col  = IDX_W'(k);
        return q;
      end
      if (!right_set[k*DIM+q.col]) begin
        q.kind = REQ_LOAD_RIGHT;
        q.row  = IDX_W'(k);
        return q;
      end
    end
    return q;
  endfunction

  // Mostly reads inside the product and loads inside the active matrices;
  // the rest are loads anywhere, reads anywhere and the unused code.
  function automatic request_t random_request();
    request_t q;
    int       r;
    r       = $urandom_range(0, 99);
    q.row   = IDX_W'($urandom_range(0, DIM - 1));
    q.col   = IDX_W'($urandom_range(0, DIM - 1));
    q.value = pick_value();
    if (r < 50) begin
      q.kind = REQ_READ;
      q.row  = IDX_W'($urandom_range(0, rows_eff - 1));
      q.col  = IDX_W'($urandom_range(0, cols_eff - 1));
    end else if (r < 65) begin
      q.kind = REQ_LOAD_LEFT;
      q.row  = IDX_W'($urandom_range(0, rows_eff - 1));
      q.col  = IDX_W'($urandom_range(0, inner_eff - 1));
    end else if (r < 80) begin
      q.kind = REQ_LOAD_RIGHT;
      q.row  = IDX_W'($urandom_range(0, inner_eff - 1));
      q.col  = IDX_W'($urandom_range(0, cols_eff - 1));
    end else if (r < 92) begin
      q.kind = $urandom_range(0, 1) ? REQ_LOAD_RIGHT : REQ_LOAD_LEFT;
    end else if (r < 97) begin
      q.kind = REQ_READ;
    end else begin
      q.kind = REQ_UNUSED;
    end
    if (q.kind == REQ_READ && !operands_ready(q.row, q.col))
      q = missing_operand(q);
    return q;
  endfunction

  task automatic run_traffic(input int count);
    repeat (count) send_request(random_request(), pick_gap());
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // 2x2 by 2x2 with corner values: saturation both ways, floor rounding of
  // negative terms, store corners loaded outside the product, reads outside
  // the product and the unused request code.
  task automatic test_directed_corners();
    set_dims(4'd2, 4'd2, 4'd2);
    send_fields(REQ_LOAD_LEFT, 3'd0, 3'd0, VAL_MAX);
    send_fields(REQ_LOAD_LEFT, 3'd0, 3'd1, VAL_MAX);
    send_fields(REQ_LOAD_LEFT, 3'd1, 3'd0, Q_ONE);
    send_fields(REQ_LOAD_LEFT, 3'd1, 3'd1, NEG_LSB);
    send_fields(REQ_LOAD_RIGHT, 3'd0, 3'd0, VAL_MAX);
    send_fields(REQ_LOAD_RIGHT, 3'd1, 3'd0, VAL_MAX);
    send_fields(REQ_LOAD_RIGHT, 3'd0, 3'd1, VAL_MIN);
    send_fields(REQ_LOAD_RIGHT, 3'd1, 3'd1, VAL_MIN);
    send_fields(REQ_LOAD_LEFT, 3'd7, 3'd7, Q_MINUS_ONE);
    send_fields(REQ_LOAD_RIGHT, 3'd7, 3'd7, 32'sd1);
    send_fields(REQ_READ, 3'd0, 3'd0, '0);
    send_fields(REQ_READ, 3'd0, 3'd1, VAL_MIN);
    send_fields(REQ_READ, 3'd1, 3'd0, VAL_MAX);
    send_fields(REQ_READ, 3'd1, 3'd1, NEG_LSB);
    send_fields(REQ_READ, 3'd2, 3'd0, '0);
    send_fields(REQ_READ, 3'd0, 3'd2, '0);
    send_fields(REQ_READ, 3'd7, 3'd7, '0);
    send_fields(REQ_UNUSED, 3'd7, 3'd7, VAL_MIN);
    send_fields(REQ_UNUSED, 3'd0, 3'd0, '0);
  endtask

  // Out-of-range register values and the unused register index.
  task automatic test_config_registers();
    set_dims(4'd0, 4'd15, 4'd9);
    write_dim(CFG_NO_REG, 4'hF);
    run_traffic(30);
    set_dims(4'd1, 4'd1, 4'd1);
    write_dim(CFG_NO_REG, 4'h0);
    run_traffic(20);
  endtask

  // Bulk random traffic over several shapes, extremes first, with the
  // idle and stall generators switched on and off per phase.
  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      gaps_on   = (p % 2 == 0);
      stalls_on = (p % 3 != 0);
      case (p)
        0: set_dims(4'd8, 4'd8, 4'd8);
        1: set_dims(4'd1, 4'd8, 4'd1);
        2: set_dims(4'd8, 4'd1, 4'd8);
        3: set_dims(4'd3, 4'd5, 4'd2);
        default: set_dims(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)),
                          DIM_W'($urandom_range(0, 15)));
      endcase
      run_traffic(130);
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Freeze the receiver while items keep coming so the queue fills and
  // in_stall rises; the hold ends on its own count.
  task automatic test_backpressure();
    set_dims(4'd8, 4'd8, 4'd8);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    run_traffic(40);
    gaps_on = 1'b1;
  endtask

  // Stop sending until every result is out, then resume.
  task automatic test_drain_pause();
    run_traffic(30);
    drain_results();
    run_traffic(40);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_LEFT_ROWS;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_req_type   = REQ_LOAD_LEFT;
    in_row_index  = '0;
    in_col_index  = '0;
    in_elem_value = '0;
    errors        = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    hold_request  = 1'b0;
    rows_eff      = effective_dim(DIM_W'(DIM_RESET_VAL));
    inner_eff     = effective_dim(DIM_W'(DIM_RESET_VAL));
    cols_eff      = effective_dim(DIM_W'(DIM_RESET_VAL));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_config_registers();
    test_random_phases();
    test_backpressure();
    test_drain_pause();

    // Wait out the last products plus the pipeline tail.
    drain_results();
    if (errors == 0) begin
      $display("PASS matrix_multiply_top");
    end else begin
      $display("FAIL matrix_multiply_top");
    end
    $finish;
  end

endmodule

// ===== matrix_multiply_top.f =====
rtl/core/mm_pkg.sv
rtl/core/mm_front.sv
rtl/core/mm_queue.sv
rtl/core/mm_back.sv
rtl/core/matrix_multiply_top.sv
tb/sv/matrix_multiply_top_test.sv
